// ----- rtl/core/wgpp_pkg.sv -----
// Shared types, codes and neighbor offsets for the wavefront grid path planner.
`default_nettype none
package wgpp_pkg;

  localparam int XW    = 10;
  localparam int YW    = 8;
  localparam int IW    = XW + YW;
  localparam int LW    = IW + 1;
  localparam int TDATA_W = 40;

  localparam logic [10:0] GRID_WIDTH  = 11'd1024;
  localparam logic [8:0]  GRID_HEIGHT = 9'd256;

  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd4;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_PLAN  = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNREACH = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_STUCK   = 2'd3;

  localparam logic [LW-1:0] LVL_FREE     = '0;
  localparam logic [LW-1:0] LVL_OBSTACLE = LW'(1);
  localparam logic [LW-1:0] LVL_GOAL     = LW'(2);

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_WRITE_CELL, DP_PLAN_SET, DP_SWP_RD, DP_SWP_WR, DP_SWP_CLR,
    DP_GOAL_RD, DP_SEED, DP_DEQ, DP_BASE_Q, DP_BASE_WALK, DP_LV_LATCH, DP_NB_RD,
    DP_WAVE_CHK, DP_STEP_CHK
  } dp_op_t;

  typedef enum logic [2:0] {
    RES_OK0, RES_RANGE, RES_UNREACH, RES_PLAN, RES_WALK_RANGE, RES_AT_GOAL,
    RES_STUCK, RES_STEP
  } res_t;

  typedef struct packed {
    dp_op_t op;
    logic   res_load;
    res_t   res;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       cell_oor;
    logic       goal_oor;
    logic       walk_oor;
    logic       at_target;
    logic       swp_last;
    logic       goal_blocked;
    logic       q_empty;
    logic       base_is_start;
    logic       lv_low;
    logic       step_hit;
    logic       k_last;
    logic       out_free;
  } dp_stat_t;

  function automatic logic [10:0] nb_dx(input logic [2:0] k);
    logic [10:0] d;
    begin
      case (k)
        3'd0, 3'd6, 3'd7: d = 11'h7FF;
        3'd1, 3'd5:       d = 11'h000;
        default:          d = 11'h001;
      endcase
      return d;
    end
  endfunction

  function automatic logic [8:0] nb_dy(input logic [2:0] k);
    logic [8:0] d;
    begin
      case (k)
        3'd0, 3'd1, 3'd2: d = 9'h1FF;
        3'd3, 3'd7:       d = 9'h000;
        default:          d = 9'h001;
      endcase
      return d;
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/wavefront_grid_path_planner_unit.sv -----
// Top level: register port, controller and datapath of the wavefront grid path planner.
//
// Channel   Direction  Contents
// s_*       in         command with cell, blocked flag and goal
// m_*       out        status, path cell, distance, at-goal flag
// APB       in/out     grid_width at 0x0, grid_height at 0x4
//
// After reset, a clearing pass writes every level cell with s_tready low.
// Write cell and next step without neighbor search go from dispatch to the result;
// a step scans up to 8 neighbors in turn. A plan sweeps all 262144 level cells, then
// checks the 8 neighbors of each dequeued cell in turn on the single level memory port.
// A new item is taken while the last result waits; its own result waits on m_tready.
`default_nettype none
module wavefront_grid_path_planner_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // command[1:0], cell_x[11:2], cell_y[19:12], blocked[20], goal_x[30:21], goal_y[38:31]
  input  logic [wgpp_pkg::TDATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status[1:0], path_x[11:2], path_y[19:12], distance[37:20], at_goal[38]
  output logic [wgpp_pkg::TDATA_W-1:0]  m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import wgpp_pkg::*;

  logic [10:0] grid_width;
  logic [8:0]  grid_height;
  ctl_cmd_t    ctl;
  dp_stat_t    stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH;
      grid_height <= GRID_HEIGHT;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr)
        REG_GRID_WIDTH:  grid_width  <= pwdata[10:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_GRID_WIDTH:  prdata = {21'd0, grid_width};
      REG_GRID_HEIGHT: prdata = {23'd0, grid_height};
      default:         prdata = 32'd0;
    endcase
  end

  wgpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  wgpp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .ctl         (ctl),
    .stat        (stat),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

  a_range_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_RANGE |-> m_tdata[38:20] == 19'd0)
    else $error("range result carries distance or goal flag");

  a_unreach_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_UNREACH |-> m_tdata[38:20] == 19'd0)
    else $error("unreachable result carries distance or goal flag");

endmodule
`default_nettype wire

// ----- rtl/core/wgpp_datapath.sv -----
// Datapath: level and frontier memories, walk and queue registers, result register.
`default_nettype none
module wgpp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [10:0]                   grid_width,
  input  logic [8:0]                    grid_height,
  input  wgpp_pkg::ctl_cmd_t            ctl,
  output wgpp_pkg::dp_stat_t            stat,
  input  logic [wgpp_pkg::TDATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [wgpp_pkg::TDATA_W-1:0]  m_tdata
);
  import wgpp_pkg::*;

  logic [LW-1:0] lvl_mem [1 << IW];
  logic [IW-1:0] q_mem   [1 << IW];

  logic [1:0]    in_cmd;
  logic [XW-1:0] in_x, in_gx, walk_x, tgt_x, base_x;
  logic [YW-1:0] in_y, in_gy, walk_y, tgt_y, base_y;
  logic          in_blk;
  logic [LW-1:0] head, tail, lv;
  logic [IW-1:0] sidx, ni;
  logic [2:0]    k;
  logic          inb;
  logic [LW-1:0] lvl_rdata;
  logic [IW-1:0] q_rdata;

  logic [10:0]   eff_w, nx;
  logic [8:0]    eff_h, ny;
  logic [IW-1:0] lvl_addr, q_waddr, q_wdata;
  logic [LW-1:0] lvl_wdata;
  logic          lvl_we, q_we;

  logic [1:0]    r_status;
  logic [XW-1:0] r_x;
  logic [YW-1:0] r_y;
  logic [IW-1:0] r_dist;
  logic          r_goal;

  assign eff_w = (grid_width == 11'd0) ? 11'd1 :
                 (grid_width > GRID_WIDTH) ? GRID_WIDTH : grid_width;
  assign eff_h = (grid_height == 9'd0) ? 9'd1 :
                 (grid_height > GRID_HEIGHT) ? GRID_HEIGHT : grid_height;
  assign nx = {1'b0, base_x} + nb_dx(k);
  assign ny = {1'b0, base_y} + nb_dy(k);

  always_comb begin
    lvl_addr  = sidx;
    lvl_we    = 1'b0;
    lvl_wdata = LVL_FREE;
    q_we      = 1'b0;
    q_waddr   = tail[IW-1:0];
    q_wdata   = ni;
    unique case (ctl.op)
      DP_WRITE_CELL: begin
        lvl_addr  = {in_y, in_x};
        lvl_we    = 1'b1;
        lvl_wdata = in_blk ? LVL_OBSTACLE : LVL_FREE;
      end
      DP_SWP_WR:    lvl_we = (lvl_rdata >= LVL_GOAL);
      DP_SWP_CLR:   lvl_we = 1'b1;
      DP_GOAL_RD:   lvl_addr = {tgt_y, tgt_x};
      DP_SEED: begin
        lvl_addr  = {tgt_y, tgt_x};
        lvl_we    = 1'b1;
        lvl_wdata = LVL_GOAL;
        q_we      = 1'b1;
        q_waddr   = '0;
        q_wdata   = {tgt_y, tgt_x};
      end
      DP_BASE_Q:    lvl_addr = q_rdata;
      DP_BASE_WALK: lvl_addr = {walk_y, walk_x};
      DP_NB_RD:     lvl_addr = {ny[YW-1:0], nx[XW-1:0]};
      DP_WAVE_CHK: begin
        lvl_addr  = ni;
        lvl_we    = inb && (lvl_rdata == LVL_FREE);
        lvl_wdata = lv + LW'(1);
        q_we      = lvl_we;
      end
      default: lvl_addr = sidx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lvl_we) lvl_mem[lvl_addr] <= lvl_wdata;
    lvl_rdata <= lvl_mem[lvl_addr];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    q_rdata <= q_mem[head[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_x   <= '0;
      walk_y   <= '0;
      tgt_x    <= '0;
      tgt_y    <= '0;
      head     <= '0;
      tail     <= '0;
      sidx     <= '0;
      k        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (ctl.op)
        DP_LOAD: begin
          in_cmd <= s_tdata[1:0];
          in_x   <= s_tdata[11:2];
          in_y   <= s_tdata[19:12];
          in_blk <= s_tdata[20];
          in_gx  <= s_tdata[30:21];
          in_gy  <= s_tdata[38:31];
        end
        DP_PLAN_SET: begin
          walk_x <= in_x;
          walk_y <= in_y;
          tgt_x  <= in_gx;
          tgt_y  <= in_gy;
          sidx   <= '0;
        end
        DP_SWP_WR, DP_SWP_CLR: sidx <= sidx + IW'(1);
        DP_SEED: begin
          head <= '0;
          tail <= LW'(1);
        end
        DP_DEQ: head <= head + LW'(1);
        DP_BASE_Q: begin
          base_x <= q_rdata[XW-1:0];
          base_y <= q_rdata[IW-1:XW];
        end
        DP_BASE_WALK: begin
          base_x <= walk_x;
          base_y <= walk_y;
        end
        DP_LV_LATCH: begin
          lv <= lvl_rdata;
          k  <= '0;
        end
        DP_NB_RD: begin
          inb <= (nx < eff_w) && (ny < eff_h);
          ni  <= {ny[YW-1:0], nx[XW-1:0]};
        end
        DP_WAVE_CHK: begin
          if (q_we) tail <= tail + LW'(1);
          k <= k + 3'd1;
        end
        DP_STEP_CHK: begin
          if (stat.step_hit) begin
            walk_x <= ni[XW-1:0];
            walk_y <= ni[IW-1:XW];
          end
          k <= k + 3'd1;
        end
        default: ;
      endcase
      if (ctl.res_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      r_x    <= walk_x;
      r_y    <= walk_y;
      r_dist <= '0;
      r_goal <= 1'b0;
      unique case (ctl.res)
        RES_OK0: begin
          r_status <= ST_OK;
          r_x <= '0;
          r_y <= '0;
        end
        RES_RANGE: begin
          r_status <= ST_RANGE;
          r_x <= '0;
          r_y <= '0;
        end
        RES_UNREACH:    r_status <= ST_UNREACH;
        RES_WALK_RANGE: r_status <= ST_RANGE;
        RES_STUCK:      r_status <= ST_STUCK;
        RES_AT_GOAL: begin
          r_status <= ST_OK;
          r_goal   <= 1'b1;
        end
        RES_PLAN: begin
          r_status <= ST_OK;
          r_dist   <= IW'(lv - LW'(2));
          r_goal   <= stat.at_target;
        end
        RES_STEP: begin
          r_status <= ST_OK;
          r_dist   <= IW'(lv - LW'(3));
          r_goal   <= stat.at_target;
        end
        default: r_status <= ST_RANGE;
      endcase
    end
  end

  assign m_tdata = {1'b0, r_goal, r_dist, r_y, r_x, r_status};

  assign stat.cmd           = in_cmd;
  assign stat.cell_oor      = ({1'b0, in_x} >= eff_w) || ({1'b0, in_y} >= eff_h);
  assign stat.goal_oor      = ({1'b0, in_gx} >= eff_w) || ({1'b0, in_gy} >= eff_h);
  assign stat.walk_oor      = ({1'b0, walk_x} >= eff_w) || ({1'b0, walk_y} >= eff_h);
  assign stat.at_target     = (walk_x == tgt_x) && (walk_y == tgt_y);
  assign stat.swp_last      = (sidx == {IW{1'b1}});
  assign stat.goal_blocked  = (lvl_rdata == LVL_OBSTACLE);
  assign stat.q_empty       = (head == tail);
  assign stat.base_is_start = (base_x == walk_x) && (base_y == walk_y);
  assign stat.lv_low        = (lvl_rdata < LW'(3));
  assign stat.step_hit      = inb && (lvl_rdata == lv - LW'(1));
  assign stat.k_last        = (k == 3'd7);
  assign stat.out_free      = !m_tvalid || m_tready;

endmodule
`default_nettype wire

// ----- rtl/core/wgpp_ctrl.sv -----
// Controller: sequences clearing, wavefront expansion, path steps and result transfer.
`default_nettype none
module wgpp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  wgpp_pkg::dp_stat_t  stat,
  output wgpp_pkg::ctl_cmd_t  ctl
);
  import wgpp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SWP_RD, S_SWP_WR, S_GOAL_RD, S_GOAL_CHK, S_DEQ, S_CELL,
    S_CELL2, S_NB_RD, S_NB_CHK, S_STEP_LV, S_SNB_RD, S_SNB_CHK, S_EMIT
  } state_t;

  state_t state, state_next;
  logic   init;
  res_t   pend, pend_next;
  dp_op_t op;

  always_comb begin
    op         = DP_NOP;
    state_next = state;
    pend_next  = pend;
    unique case (state)
      S_IDLE: if (s_tvalid) begin
        op         = DP_LOAD;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_next = S_EMIT;
        case (stat.cmd)
          CMD_WRITE: begin
            if (stat.cell_oor) pend_next = RES_RANGE;
            else begin
              op        = DP_WRITE_CELL;
              pend_next = RES_OK0;
            end
          end
          CMD_PLAN: begin
            if (stat.cell_oor || stat.goal_oor) pend_next = RES_RANGE;
            else begin
              op         = DP_PLAN_SET;
              state_next = S_SWP_RD;
            end
          end
          CMD_STEP: begin
            if (stat.walk_oor) pend_next = RES_WALK_RANGE;
            else if (stat.at_target) pend_next = RES_AT_GOAL;
            else begin
              op         = DP_BASE_WALK;
              state_next = S_STEP_LV;
            end
          end
          default: pend_next = RES_RANGE;
        endcase
      end
      S_SWP_RD: begin
        op         = DP_SWP_RD;
        state_next = S_SWP_WR;
      end
      S_SWP_WR: begin
        op = init ? DP_SWP_CLR : DP_SWP_WR;
        if (!stat.swp_last) state_next = S_SWP_RD;
        else state_next = init ? S_IDLE : S_GOAL_RD;
      end
      S_GOAL_RD: begin
        op         = DP_GOAL_RD;
        state_next = S_GOAL_CHK;
      end
      S_GOAL_CHK: begin
        if (stat.goal_blocked) begin
          pend_next  = RES_UNREACH;
          state_next = S_EMIT;
        end else begin
          op         = DP_SEED;
          state_next = S_DEQ;
        end
      end
      S_DEQ: begin
        if (stat.q_empty) begin
          pend_next  = RES_UNREACH;
          state_next = S_EMIT;
        end else begin
          op         = DP_DEQ;
          state_next = S_CELL;
        end
      end
      S_CELL: begin
        op         = DP_BASE_Q;
        state_next = S_CELL2;
      end
      S_CELL2: begin
        op = DP_LV_LATCH;
        if (stat.base_is_start) begin
          pend_next  = RES_PLAN;
          state_next = S_EMIT;
        end else state_next = S_NB_RD;
      end
      S_NB_RD: begin
        op         = DP_NB_RD;
        state_next = S_NB_CHK;
      end
      S_NB_CHK: begin
        op         = DP_WAVE_CHK;
        state_next = stat.k_last ? S_DEQ : S_NB_RD;
      end
      S_STEP_LV: begin
        op = DP_LV_LATCH;
        if (stat.lv_low) begin
          pend_next  = RES_STUCK;
          state_next = S_EMIT;
        end else state_next = S_SNB_RD;
      end
      S_SNB_RD: begin
        op         = DP_NB_RD;
        state_next = S_SNB_CHK;
      end
      S_SNB_CHK: begin
        op = DP_STEP_CHK;
        if (stat.step_hit) begin
          pend_next  = RES_STEP;
          state_next = S_EMIT;
        end else if (stat.k_last) begin
          pend_next  = RES_STUCK;
          state_next = S_EMIT;
        end else state_next = S_SNB_RD;
      end
      S_EMIT: if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWP_RD;
      init  <= 1'b1;
      pend  <= RES_OK0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      if (state == S_SWP_WR && stat.swp_last) init <= 1'b0;
    end
  end

  assign s_tready     = (state == S_IDLE);
  assign ctl.op       = op;
  assign ctl.res_load = (state == S_EMIT) && stat.out_free;
  assign ctl.res      = pend;

endmodule
`default_nettype wire

// ----- verif/wavefront_grid_path_planner_unit_tb.sv -----
// Self-checking testbench for the wavefront grid path planner: directed table then random plans.
`timescale 1ns / 100ps
`default_nettype none
module wavefront_grid_path_planner_unit_tb;
  import wgpp_pkg::*;

  localparam int CELLS = 1024 * 256;
  localparam longint CYCLE_LIMIT = 100_000_000;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct {
    logic [1:0]  status;
    logic [9:0]  px;
    logic [7:0]  py;
    logic [17:0] distance;
    logic        at_goal;
  } path_result_t;

  typedef enum logic {ROW_ITEM, ROW_GRID} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [1:0]   cmd;
    logic [9:0]   cx;
    logic [7:0]   cy;
    logic         blk;
    logic [9:0]   gx;
    logic [7:0]   gy;
    logic [10:0]  width_val;
    logic [8:0]   height_val;
    bit           typed;
    path_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  wavefront_grid_path_planner_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  int unsigned level_map [CELLS];
  int unsigned wave_q [$];
  logic [10:0] width_reg = 11'd1024;
  logic [8:0]  height_reg = 9'd256;
  int unsigned walk_x, walk_y, target_x, target_y;
  const int nbx [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};
  const int nby [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};

  path_result_t expected_results [$];
  stim_row_t rows [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int plans_sent = 0;
  int steps_sent = 0;
  longint cycles = 0;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > 1024) w = 1024;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > 256) h = 256;
    return h;
  endfunction

  function automatic path_result_t mk(int unsigned st, int unsigned x, int unsigned y,
                                     int unsigned d, int unsigned g);
    path_result_t r;
    r.status = st[1:0];
    r.px = x[9:0];
    r.py = y[7:0];
    r.distance = d[17:0];
    r.at_goal = g[0];
    return r;
  endfunction

  function automatic bit spread_wave(int unsigned sx, int unsigned sy,
                                     int unsigned w, int unsigned h);
    int unsigned c, cx, cy, lv, ni;
    int nx, ny;
    for (int i = 0; i < CELLS; i++)
      if (level_map[i] >= 2) level_map[i] = 0;
    wave_q.delete();
    if (level_map[target_y * 1024 + target_x] == 1) return 0;
    level_map[target_y * 1024 + target_x] = 2;
    wave_q.insert(wave_q.size(), target_y * 1024 + target_x);
    while (wave_q.size() != 0) begin
      c = wave_q.pop_front();
      cx = c % 1024;
      cy = c / 1024;
      if (cx == sx && cy == sy) return 1;
      lv = level_map[c] + 1;
      for (int k = 0; k < 8; k++) begin
        nx = int'(cx) + nbx[k];
        ny = int'(cy) + nby[k];
        if (nx < 0 || ny < 0 || nx >= int'(w) || ny >= int'(h)) continue;
        ni = ny * 1024 + nx;
        if (level_map[ni] != 0) continue;
        level_map[ni] = lv;
        wave_q.insert(wave_q.size(), ni);
      end
    end
    return 0;
  endfunction

  function automatic path_result_t predict_path(stim_row_t it);
    int unsigned w, h, lv, cost;
    int nx, ny;
    w = eff_width();
    h = eff_height();
    case (it.cmd)
      CMD_WRITE: begin
        if (it.cx >= w || it.cy >= h) return mk(ST_RANGE, 0, 0, 0, 0);
        level_map[it.cy * 1024 + it.cx] = it.blk ? 1 : 0;
        return mk(ST_OK, 0, 0, 0, 0);
      end
      CMD_PLAN: begin
        if (it.cx >= w || it.cy >= h || it.gx >= w || it.gy >= h)
          return mk(ST_RANGE, 0, 0, 0, 0);
        walk_x = it.cx;
        walk_y = it.cy;
        target_x = it.gx;
        target_y = it.gy;
        if (!spread_wave(it.cx, it.cy, w, h)) return mk(ST_UNREACH, it.cx, it.cy, 0, 0);
        return mk(ST_OK, it.cx, it.cy, level_map[it.cy * 1024 + it.cx] - 2,
                  (it.cx == it.gx && it.cy == it.gy));
      end
      CMD_STEP: begin
        if (walk_x >= w || walk_y >= h) return mk(ST_RANGE, walk_x, walk_y, 0, 0);
        if (walk_x == target_x && walk_y == target_y) return mk(ST_OK, walk_x, walk_y, 0, 1);
        lv = level_map[walk_y * 1024 + walk_x];
        if (lv < 3) return mk(ST_STUCK, walk_x, walk_y, 0, 0);
        cost = lv - 1;
        for (int k = 0; k < 8; k++) begin
          nx = int'(walk_x) + nbx[k];
          ny = int'(walk_y) + nby[k];
          if (nx < 0 || ny < 0 || nx >= int'(w) || ny >= int'(h)) continue;
          if (level_map[ny * 1024 + nx] != cost) continue;
          walk_x = nx;
          walk_y = ny;
          return mk(ST_OK, walk_x, walk_y, cost - 2,
                    (walk_x == target_x && walk_y == target_y));
        end
        return mk(ST_STUCK, walk_x, walk_y, 0, 0);
      end
      default: return mk(ST_RANGE, 0, 0, 0, 0);
    endcase
  endfunction

  function automatic stim_row_t item(logic [1:0] cmd, int unsigned cx, int unsigned cy,
                                     bit blk, int unsigned gx, int unsigned gy);
    stim_row_t r;
    r = '{kind: ROW_ITEM, default: '0};
    r.cmd = cmd;
    r.cx = cx[9:0];
    r.cy = cy[7:0];
    r.blk = blk;
    r.gx = gx[9:0];
    r.gy = gy[7:0];
    return r;
  endfunction

  function automatic void add(logic [1:0] cmd, int unsigned cx, int unsigned cy, bit blk,
                              int unsigned gx, int unsigned gy);
    rows.insert(rows.size(), item(cmd, cx, cy, blk, gx, gy));
  endfunction

  function automatic void add_exp(logic [1:0] cmd, int unsigned cx, int unsigned cy, bit blk,
                                  int unsigned gx, int unsigned gy, path_result_t res);
    stim_row_t r;
    r = item(cmd, cx, cy, blk, gx, gy);
    r.typed = 1;
    r.res = res;
    rows.insert(rows.size(), r);
  endfunction

  function automatic void add_grid(int unsigned w, int unsigned h);
    stim_row_t r;
    r = '{kind: ROW_GRID, default: '0};
    r.width_val = w[10:0];
    r.height_val = h[8:0];
    rows.insert(rows.size(), r);
  endfunction

  task automatic apb_write(logic [2:0] addr, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_grid(logic [10:0] w, logic [8:0] h);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    apb_write(REG_GRID_WIDTH, {21'd0, w});
    apb_write(REG_GRID_HEIGHT, {23'd0, h});
    width_reg = w;
    height_reg = h;
  endtask

  task automatic send_item(stim_row_t it);
    path_result_t p;
    bit quiet;
    quiet = (items_sent >= 40 && items_sent < 65);
    if (!quiet && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, it.gy, it.gx, it.blk, it.cy, it.cx, it.cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    p = predict_path(it);
    expected_results.insert(expected_results.size(), it.typed ? it.res : p);
    items_sent++;
    if (it.cmd == CMD_PLAN) plans_sent++;
    if (it.cmd == CMD_STEP) steps_sent++;
  endtask

  task automatic run_row(stim_row_t r);
    if (r.kind == ROW_GRID) begin
      s_tvalid <= 1'b0;
      set_grid(r.width_val, r.height_val);
    end else begin
      send_item(r);
    end
  endtask

  always @(posedge clk) begin
    path_result_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst) begin
      m_tready <= (results_seen >= 40 && results_seen < 65) ? 1'b1 : ($urandom_range(99) >= 30);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no expectation: %h", m_tdata);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (m_tdata[1:0] != e.status) begin
            $error("status expected %0d actual %0d", e.status, m_tdata[1:0]);
            errors++;
          end
          if (m_tdata[11:2] != e.px) begin
            $error("path_x expected %0d actual %0d", e.px, m_tdata[11:2]);
            errors++;
          end
          if (m_tdata[19:12] != e.py) begin
            $error("path_y expected %0d actual %0d", e.py, m_tdata[19:12]);
            errors++;
          end
          if (m_tdata[37:20] != e.distance) begin
            $error("distance expected %0d actual %0d", e.distance, m_tdata[37:20]);
            errors++;
          end
          if (m_tdata[38] != e.at_goal) begin
            $error("at_goal expected %0d actual %0d", e.at_goal, m_tdata[38]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned w, h, gx, gy, sx, sy;
    stim_row_t r;
    foreach (level_map[i]) level_map[i] = 0;
    walk_x = 0;
    walk_y = 0;
    target_x = 0;
    target_y = 0;

    add_exp(CMD_STEP, 0, 0, 0, 0, 0, mk(ST_OK, 0, 0, 0, 1));
    add_exp(CMD_SPARE, 1023, 255, 1, 1023, 255, mk(ST_RANGE, 0, 0, 0, 0));
    add_exp(CMD_WRITE, 1023, 255, 1, 0, 0, mk(ST_OK, 0, 0, 0, 0));
    add_exp(CMD_PLAN, 1022, 254, 0, 1023, 255, mk(ST_UNREACH, 1022, 254, 0, 0));
    add_exp(CMD_WRITE, 1023, 255, 0, 0, 0, mk(ST_OK, 0, 0, 0, 0));
    add(CMD_PLAN, 1022, 254, 0, 1023, 255);
    add(CMD_STEP, 0, 0, 0, 0, 0);
    add_exp(CMD_STEP, 0, 0, 0, 0, 0, mk(ST_OK, 1023, 255, 0, 1));
    add_grid(8, 6);
    add_exp(CMD_WRITE, 8, 0, 1, 0, 0, mk(ST_RANGE, 0, 0, 0, 0));
    add_exp(CMD_WRITE, 0, 6, 1, 0, 0, mk(ST_RANGE, 0, 0, 0, 0));
    add_exp(CMD_STEP, 0, 0, 0, 0, 0, mk(ST_RANGE, 1023, 255, 0, 0));
    add_exp(CMD_PLAN, 0, 0, 0, 8, 0, mk(ST_RANGE, 0, 0, 0, 0));
    for (int y = 0; y < 5; y++) add(CMD_WRITE, 3, y, 1, 0, 0);
    add(CMD_PLAN, 0, 0, 0, 7, 5);
    repeat (4) add(CMD_STEP, 0, 0, 0, 0, 0);
    add(CMD_WRITE, 3, 5, 1, 0, 0);
    add_exp(CMD_PLAN, 0, 0, 0, 7, 5, mk(ST_UNREACH, 0, 0, 0, 0));
    add(CMD_PLAN, 0, 0, 0, 1, 0);
    add(CMD_WRITE, 1, 0, 1, 0, 0);
    add_exp(CMD_STEP, 0, 0, 0, 0, 0, mk(ST_STUCK, 0, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) run_row(rows[i]);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin w = 4; h = 4; end
        1: begin w = 0; h = 0; end
        2: begin w = 2047; h = 511; end
        3: begin w = 16; h = 8; end
        default: begin w = 6; h = 3; end
      endcase
      s_tvalid <= 1'b0;
      set_grid(w, h);
      w = eff_width();
      h = eff_height();
      repeat (2) begin
        repeat (3) begin
          if ($urandom_range(99) < 10)
            r = item(CMD_SPARE, $urandom_range(1023), $urandom_range(255), $urandom_range(1),
                     $urandom_range(1023), $urandom_range(255));
          else if ($urandom_range(99) < 80)
            r = item(CMD_WRITE, $urandom_range(w - 1), $urandom_range(h - 1),
                     $urandom_range(99) < 30, $urandom_range(1023), $urandom_range(255));
          else
            r = item(CMD_WRITE, $urandom_range(1023), $urandom_range(255),
                     $urandom_range(1), $urandom_range(1023), $urandom_range(255));
          send_item(r);
        end
        gx = $urandom_range(w - 1);
        gy = $urandom_range(h - 1);
        if (w == 1024) begin
          // keep the start next to the goal so the wave ends early
          sx = (gx == 0) ? gx + $urandom_range(1) : gx - $urandom_range(1);
          sy = (gy == 0) ? gy + $urandom_range(1) : gy - $urandom_range(1);
        end else begin
          sx = $urandom_range(w - 1);
          sy = $urandom_range(h - 1);
        end
        send_item(item(CMD_WRITE, sx, sy, 0, 0, 0));
        if ($urandom_range(99) < 15)
          send_item(item(CMD_PLAN, sx, sy, 0, $urandom_range(1023), $urandom_range(255)));
        send_item(item(CMD_PLAN, sx, sy, 0, gx, gy));
        repeat ($urandom_range(5, 2)) send_item(item(CMD_STEP, 0, 0, 0, 0, 0));
      end
    end

    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Ran %0d commands (%0d plans, %0d steps), checked %0d results.",
             items_sent, plans_sent, steps_sent, results_seen);
    $display("Grids from 1x1 to 1024x256, obstacles, unreachable, stuck and range cases.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
